// ----- hdl/gpeg_pkg.sv -----
// Shared constants, types and the key table of the gamepad poll event generator.
// No dependencies; compile first.
`timescale 1ns / 1ps

package gpeg_pkg;

    localparam int GPEG_NKEYS  = 14;
    localparam int GPEG_NAXES  = 6;
    localparam int GPEG_ADDR_W = 4;

    localparam logic [15:0] Q_ONE_MAX = 16'h7FFF;
    localparam logic [15:0] Q_NEG_MAX = 16'h8000;
    localparam logic [7:0]  TRIG_FULL = 8'hFF;
    localparam logic [14:0] STICK_FULL = 15'h7FFF;

    localparam logic [7:0]  TRIG_THR_RESET = 8'd30;
    localparam logic [14:0] LDZ_RESET      = 15'd7849;
    localparam logic [14:0] RDZ_RESET      = 15'd8689;

    localparam logic [3:0] KEY_DPAD_FIRST = 4'd6;
    localparam logic [3:0] KEY_DPAD_LAST  = 4'd9;
    localparam logic [3:0] KEY_LAST       = 4'd13;
    localparam logic [2:0] AXIS_LAST      = 3'd5;

    // Quotient bits produced by the shared divider
    localparam logic [4:0] DIV_STEPS = 5'd17;

    typedef enum logic [1:0] {
        EV_PRESS   = 2'd0,
        EV_RELEASE = 2'd1,
        EV_AXIS    = 2'd2
    } t_ev_kind;

    typedef enum logic [1:0] {
        REG_TRIG_THR = 2'd0,
        REG_LEFT_DZ  = 2'd1,
        REG_RIGHT_DZ = 2'd2
    } t_reg_idx;

    typedef enum logic {
        OP_POLL = 1'b0,
        OP_LOST = 1'b1
    } t_op;

    // Bit position in the button mask of each key, in key index order
    function automatic logic [3:0] key_bit_pos(input logic [3:0] k);
        logic [3:0] pos;
        case (k)
            4'd0:    pos = 4'd12;
            4'd1:    pos = 4'd13;
            4'd2:    pos = 4'd14;
            4'd3:    pos = 4'd15;
            4'd4:    pos = 4'd5;
            4'd5:    pos = 4'd4;
            4'd6:    pos = 4'd2;
            4'd7:    pos = 4'd3;
            4'd8:    pos = 4'd0;
            4'd9:    pos = 4'd1;
            4'd10:   pos = 4'd6;
            4'd11:   pos = 4'd7;
            4'd12:   pos = 4'd8;
            4'd13:   pos = 4'd9;
            default: pos = 4'd10;
        endcase
        return pos;
    endfunction

endpackage

// ----- hdl/gpeg_if.sv -----
// Valid/ready channel interfaces: poll requests in, events out.
// No dependencies.
`timescale 1ns / 1ps

interface gpeg_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic [15:0]        button_mask;
    logic [7:0]         left_trigger;
    logic [7:0]         right_trigger;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;

    modport source (
        output valid, op, button_mask, left_trigger, right_trigger,
               left_x, left_y, right_x, right_y,
        input  ready
    );
    modport sink (
        input  valid, op, button_mask, left_trigger, right_trigger,
               left_x, left_y, right_x, right_y,
        output ready
    );
endinterface

interface gpeg_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         event_kind;
    logic [3:0]         event_code;
    logic signed [15:0] event_value;
    logic               last;

    modport source (
        output valid, event_kind, event_code, event_value, last,
        input  ready
    );
    modport sink (
        input  valid, event_kind, event_code, event_value, last,
        output ready
    );
endinterface

// ----- hdl/gamepad_poll_event_generator.sv -----
// Gamepad poll event generator: button edge events and deadzone-normalized axes.
// Depends on gpeg_pkg and the channel interfaces in gpeg_if.sv.
//
// Usage:
//   i_in carries one request per poll: a sample (op 0) or a device-lost
//   request (op 1). o_ev carries the events it causes, up to eighteen, the
//   final one flagged by last. A request that causes no event yields nothing.
//   Registers (APB, byte address 4*i): trigger threshold, left and right
//   stick deadzones. Write them only while the block is idle.
//   One request is worked at a time; i_in.ready is high only when idle.
//   A sample scans the keys in order, then works each axis in turn: a setup
//   step, 17 steps of the shared bit-serial divider and an emit step. Axes in
//   the dead band skip the divider, as do all axes of a device-lost request.
//   Events leave through an output register, with one more event held back
//   so that last can be set; while that register is full and o_ev.ready is low
//   the sequencer halts at its next key, emit or finish step until it frees up.
//   Reset (i_rst_n low, synchronous) restores the register defaults and
//   clears previous buttons, held keys, d-pad owner and axis history.
`timescale 1ns / 1ps

module gamepad_poll_event_generator
    import gpeg_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    gpeg_in_if.sink                i_in,
    gpeg_out_if.source             o_ev,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [GPEG_ADDR_W-1:0] paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_KEYS,
        S_AX_SETUP,
        S_AX_DIV,
        S_AX_EMIT,
        S_FINISH
    } t_state;

    t_state r_state;

    // configuration
    logic [7:0]  r_thr;
    logic [14:0] r_ldz;
    logic [14:0] r_rdz;

    // latched request
    logic               r_op;
    logic [15:0]        r_now;
    logic [7:0]         r_lt;
    logic [7:0]         r_rt;
    logic signed [15:0] r_lx;
    logic signed [15:0] r_ly;
    logic signed [15:0] r_rx;
    logic signed [15:0] r_ry;

    // persistent state
    logic [15:0]        r_prev;
    logic [13:0]        r_held;
    logic [3:0]         r_owner;
    logic signed [15:0] r_axis [GPEG_NAXES];

    // sequencer
    logic [3:0] r_idx;
    logic [2:0] r_ax;

    // shared divider
    logic [14:0] r_rem;
    logic [16:0] r_bits;
    logic [16:0] r_quo;
    logic [4:0]  r_cnt;
    logic [14:0] r_div;
    logic        r_neg;

    // held-back event and output register
    logic        r_pv;
    t_ev_kind    r_pk;
    logic [3:0]  r_pc;
    logic [15:0] r_pval;
    logic        r_ov;
    t_ev_kind    r_ok;
    logic [3:0]  r_oc;
    logic [15:0] r_oval;
    logic        r_olast;

    logic o_free;
    logic cfg_wr;

    // key scan
    logic [3:0]  k_pos;
    logic        k_now;
    logic        k_prev;
    logic        k_dpad;
    logic [1:0]  k_dsel;
    logic [3:0]  k_own;
    logic        k_fire;
    t_ev_kind    k_kind;
    logic [13:0] n_held;
    logic [3:0]  n_owner;

    // axis setup
    logic [7:0]         a_tv;
    logic signed [15:0] a_sv;
    logic [14:0]        a_dz;
    logic signed [16:0] a_sv17;
    logic signed [16:0] a_dz17;
    logic signed [16:0] a_diff;
    logic               a_zero;
    logic               a_neg;
    logic [15:0]        a_mag;
    logic [14:0]        a_span;
    logic [15:0]        a_q;

    // divider step
    logic [15:0] d_trial;
    logic        d_ge;
    logic [15:0] d_sub;

    // event select
    logic        ev_fire;
    t_ev_kind    ev_kind;
    logic [3:0]  ev_code;
    logic [15:0] ev_val;
    logic        fin_fire;

    assign o_free = !r_ov || o_ev.ready;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_ev.valid       = r_ov;
    assign o_ev.event_kind  = r_ok;
    assign o_ev.event_code  = r_oc;
    assign o_ev.event_value = r_oval;
    assign o_ev.last        = r_olast;

    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_TRIG_THR: prdata = 32'(r_thr);
            REG_LEFT_DZ:  prdata = 32'(r_ldz);
            REG_RIGHT_DZ: prdata = 32'(r_rdz);
            default:      prdata = 32'd0;
        endcase
    end

    // One key per cycle while the output register is free: edge detect against the previous mask, d-pad ownership
    always_comb begin
        k_pos   = key_bit_pos(r_idx);
        k_now   = r_now[k_pos];
        k_prev  = r_prev[k_pos];
        k_dpad  = (r_idx >= KEY_DPAD_FIRST) && (r_idx <= KEY_DPAD_LAST);
        k_dsel  = 2'(r_idx - KEY_DPAD_FIRST);
        k_own   = k_dpad ? (4'b0001 << k_dsel) : 4'b0000;
        k_fire  = 1'b0;
        k_kind  = EV_PRESS;
        n_held  = r_held;
        n_owner = r_owner;
        if (r_op == OP_LOST) begin
            if (r_held[r_idx]) begin
                k_fire = 1'b1;
                k_kind = EV_RELEASE;
            end
        end else if (k_now && !k_prev) begin
            if (!(k_dpad && (r_owner != 4'b0000))) begin
                n_owner       = r_owner | k_own;
                n_held[r_idx] = 1'b1;
                k_fire        = 1'b1;
                k_kind        = EV_PRESS;
            end
        end else if (!k_now && k_prev) begin
            if (!(k_dpad && ((r_owner & k_own) == 4'b0000))) begin
                n_owner       = r_owner & ~k_own;
                n_held[r_idx] = 1'b0;
                k_fire        = 1'b1;
                k_kind        = EV_RELEASE;
            end
        end
    end

    // Dead band test and divider operands for the current axis
    always_comb begin
        a_tv = (r_ax == 3'd0) ? r_lt : r_rt;
        case (r_ax)
            3'd2:    a_sv = r_lx;
            3'd3:    a_sv = r_ly;
            3'd4:    a_sv = r_rx;
            default: a_sv = r_ry;
        endcase
        a_dz   = (r_ax < 3'd4) ? r_ldz : r_rdz;
        a_sv17 = {a_sv[15], a_sv};
        a_dz17 = $signed({2'b00, a_dz});
        a_diff = 17'sd0;
        a_neg  = 1'b0;
        if (r_ax < 3'd2) begin
            a_zero = (r_thr == TRIG_FULL) || (a_tv <= r_thr);
            a_mag  = {8'd0, 8'(a_tv - r_thr)};
            a_span = {7'd0, 8'(TRIG_FULL - r_thr)};
        end else begin
            a_span = STICK_FULL - a_dz;
            if (a_sv17 > a_dz17) begin
                a_zero = 1'b0;
                a_diff = a_sv17 - a_dz17;
            end else if (a_sv17 < -a_dz17) begin
                a_zero = 1'b0;
                a_neg  = 1'b1;
                a_diff = -a_sv17 - a_dz17;
            end else begin
                a_zero = 1'b1;
            end
            if (a_dz == STICK_FULL) begin
                a_zero = 1'b1;
            end
            a_mag = a_diff[15:0];
        end
    end

    // Restoring divider step and saturation of the quotient
    always_comb begin
        d_trial = {r_rem, r_bits[16]};
        d_ge    = (d_trial >= {1'b0, r_div});
        d_sub   = d_trial - {1'b0, r_div};
        if (!r_neg) begin
            a_q = (r_quo > 17'd32767) ? Q_ONE_MAX : r_quo[15:0];
        end else begin
            a_q = (r_quo > 17'd32768) ? Q_NEG_MAX : 16'(17'd0 - r_quo);
        end
    end

    always_comb begin
        ev_fire = 1'b0;
        ev_kind = EV_AXIS;
        ev_code = {1'b0, r_ax};
        ev_val  = a_q;
        case (r_state)
            S_KEYS: begin
                ev_fire = o_free && k_fire;
                ev_kind = k_kind;
                ev_code = r_idx;
                ev_val  = (k_kind == EV_PRESS) ? Q_ONE_MAX : 16'd0;
            end
            S_AX_EMIT: begin
                ev_fire = o_free && ((a_q != 16'd0) || (r_axis[r_ax] != 16'sd0));
            end
            default: begin
                ev_fire = 1'b0;
            end
        endcase
        fin_fire = (r_state == S_FINISH) && o_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_thr   <= TRIG_THR_RESET;
            r_ldz   <= LDZ_RESET;
            r_rdz   <= RDZ_RESET;
            r_prev  <= 16'd0;
            r_held  <= 14'd0;
            r_owner <= 4'd0;
            for (int i = 0; i < GPEG_NAXES; i++) begin
                r_axis[i] <= 16'sd0;
            end
            r_idx   <= 4'd0;
            r_ax    <= 3'd0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (t_reg_idx'(paddr[3:2]))
                    REG_TRIG_THR: r_thr <= pwdata[7:0];
                    REG_LEFT_DZ:  r_ldz <= pwdata[14:0];
                    REG_RIGHT_DZ: r_rdz <= pwdata[14:0];
                    default: ;
                endcase
            end

            if (o_ev.valid && o_ev.ready) begin
                r_ov <= 1'b0;
            end
            // hold each new event back one step so last can be set on the final one
            if (ev_fire) begin
                if (r_pv) begin
                    r_ov    <= 1'b1;
                    r_ok    <= r_pk;
                    r_oc    <= r_pc;
                    r_oval  <= r_pval;
                    r_olast <= 1'b0;
                end
                r_pv   <= 1'b1;
                r_pk   <= ev_kind;
                r_pc   <= ev_code;
                r_pval <= ev_val;
            end
            if (fin_fire && r_pv) begin
                r_ov    <= 1'b1;
                r_ok    <= r_pk;
                r_oc    <= r_pc;
                r_oval  <= r_pval;
                r_olast <= 1'b1;
                r_pv    <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_op    <= i_in.op;
                        r_now   <= i_in.button_mask;
                        r_lt    <= i_in.left_trigger;
                        r_rt    <= i_in.right_trigger;
                        r_lx    <= i_in.left_x;
                        r_ly    <= i_in.left_y;
                        r_rx    <= i_in.right_x;
                        r_ry    <= i_in.right_y;
                        r_idx   <= 4'd0;
                        r_state <= S_KEYS;
                    end
                end
                S_KEYS: begin
                    if (o_free) begin
                        r_held  <= n_held;
                        r_owner <= n_owner;
                        if (r_idx == KEY_LAST) begin
                            r_ax    <= 3'd0;
                            r_state <= S_AX_SETUP;
                        end else begin
                            r_idx <= r_idx + 4'd1;
                        end
                    end
                end
                S_AX_SETUP: begin
                    r_rem  <= {1'b0, a_mag[15:2]};
                    r_bits <= {a_mag[1:0], 15'd0};
                    r_quo  <= 17'd0;
                    r_cnt  <= DIV_STEPS;
                    r_div  <= a_span;
                    r_neg  <= a_neg;
                    if ((r_op == OP_LOST) || a_zero) begin
                        r_neg   <= 1'b0;
                        r_state <= S_AX_EMIT;
                    end else begin
                        r_state <= S_AX_DIV;
                    end
                end
                S_AX_DIV: begin
                    r_rem  <= d_ge ? d_sub[14:0] : d_trial[14:0];
                    r_quo  <= {r_quo[15:0], d_ge};
                    r_bits <= {r_bits[15:0], 1'b0};
                    r_cnt  <= r_cnt - 5'd1;
                    if (r_cnt == 5'd1) begin
                        r_state <= S_AX_EMIT;
                    end
                end
                S_AX_EMIT: begin
                    if (o_free) begin
                        r_axis[r_ax] <= a_q;
                        if (r_ax == AXIS_LAST) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_ax    <= r_ax + 3'd1;
                            r_state <= S_AX_SETUP;
                        end
                    end
                end
                S_FINISH: begin
                    if (o_free) begin
                        if (r_op == OP_LOST) begin
                            r_prev  <= 16'd0;
                            r_held  <= 14'd0;
                            r_owner <= 4'd0;
                        end else begin
                            r_prev <= r_now;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !r_pv)
        else $error("held-back event left over when idle");

    a_owner_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_owner))
        else $error("more than one d-pad direction owned");

    a_owner_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held[9:6] == r_owner)
        else $error("d-pad held keys disagree with owner");

    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ev.valid && !o_ev.last) |-> r_pv)
        else $error("non-final event without a following event");
`endif

endmodule

// ----- sim/tb.sv -----
// Self-checking bench for gamepad_poll_event_generator: a directed table, then random polls
// under several register settings, each event checked against table or in-bench predictor.
// Depends on gpeg_pkg, the channel interfaces in gpeg_if.sv and the block itself.
`timescale 1ns / 1ps

module tb;
    import gpeg_pkg::*;

    localparam int PREDICTED    = -1;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_AFTER   = 80;
    localparam int HOLD_CYCLES  = 400;
    localparam int PRINT_CAP    = 40;

    // Mask bit of each key, in key index order
    localparam logic [3:0] KEY_POS [0:13] = '{
        4'd12, 4'd13, 4'd14, 4'd15, 4'd5, 4'd4, 4'd2,
        4'd3, 4'd0, 4'd1, 4'd6, 4'd7, 4'd8, 4'd9
    };

    typedef struct packed {
        t_op                op;
        logic [15:0]        mask;
        logic [7:0]         lt;
        logic [7:0]         rt;
        logic signed [15:0] lx;
        logic signed [15:0] ly;
        logic signed [15:0] rx;
        logic signed [15:0] ry;
    } gp_req_t;

    typedef struct packed {
        t_ev_kind           kind;
        logic [3:0]         code;
        logic signed [15:0] value;
        logic               last;
    } gp_event_t;

    typedef struct {
        logic        wr_cfg;
        logic [7:0]  thr;
        logic [14:0] ldz;
        logic [14:0] rdz;
        gp_req_t     req;
        int          n_typed;
        gp_event_t   ev0;
        gp_event_t   ev1;
    } gp_row_t;

    localparam gp_event_t NO_EVENT = '0;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [GPEG_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    gpeg_in_if  in_ch ();
    gpeg_out_if ev_ch ();

    gamepad_poll_event_generator uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_ev    (ev_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state and register shadow
    logic [7:0]         cfg_thr   = TRIG_THR_RESET;
    logic [14:0]        cfg_ldz   = LDZ_RESET;
    logic [14:0]        cfg_rdz   = RDZ_RESET;
    logic [15:0]        prev_mask = '0;
    logic [13:0]        held_keys = '0;
    logic [3:0]         pad_owner = '0;
    logic signed [15:0] axis_hist [0:5] = '{default: '0};

    gp_event_t derived_events [$];
    gp_event_t owed_events [$];
    gp_row_t   dir_rows [$];

    logic [15:0] stim_mask   = '0;
    bit          calm        = 1'b0;
    int          mismatches  = 0;
    int          events_seen = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(5_000_000);
        $display("Verification failed");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        if (mismatches < PRINT_CAP) $display("MISMATCH at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic logic signed [15:0] sat_q15(input longint x);
        if (x > 32767) return Q_ONE_MAX;
        if (x < -32768) return Q_NEG_MAX;
        return 16'(x);
    endfunction

    function automatic logic signed [15:0] trigger_q(input logic [7:0] v, input logic [7:0] t);
        longint vi;
        longint ti;
        vi = v;
        ti = t;
        if (t == TRIG_FULL || v <= t) return '0;
        return sat_q15((vi - ti) * 32768 / (255 - ti));
    endfunction

    function automatic logic signed [15:0] stick_q(input logic signed [15:0] v,
                                                   input logic [14:0] d);
        longint vi;
        longint di;
        longint span;
        vi = v;
        di = d;
        span = 32767 - di;
        if (span <= 0) return '0;
        if (vi > di) return sat_q15((vi - di) * 32768 / span);
        if (vi < -di) return sat_q15((vi + di) * 32768 / span);
        return '0;
    endfunction

    function automatic void add_event(input t_ev_kind kind, input int code,
                                      input logic signed [15:0] value);
        gp_event_t e;
        e.kind  = kind;
        e.code  = 4'(code);
        e.value = value;
        e.last  = 1'b0;
        derived_events.push_back(e);
    endfunction

    function automatic void set_axis(input int idx, input logic signed [15:0] q);
        logic signed [15:0] old;
        old = axis_hist[idx];
        axis_hist[idx] = q;
        if (q != 0 || old != 0) add_event(EV_AXIS, idx, q);
    endfunction

    function automatic void derive_events(input gp_req_t r);
        logic [15:0] chg;
        logic [15:0] pressed;
        logic [15:0] released;
        logic [3:0]  own;
        logic        pad;
        derived_events.delete();
        if (r.op == OP_LOST) begin
            for (int k = 0; k < GPEG_NKEYS; k++)
                if (held_keys[k]) add_event(EV_RELEASE, k, 16'sd0);
            for (int a = 0; a < GPEG_NAXES; a++)
                if (axis_hist[a] != 0) add_event(EV_AXIS, a, 16'sd0);
            prev_mask = '0;
            held_keys = '0;
            pad_owner = '0;
            for (int a = 0; a < GPEG_NAXES; a++) axis_hist[a] = '0;
        end else begin
            chg      = prev_mask ^ r.mask;
            pressed  = chg & r.mask;
            released = chg & ~r.mask;
            for (int k = 0; k < GPEG_NKEYS; k++) begin
                pad = (k >= int'(KEY_DPAD_FIRST)) && (k <= int'(KEY_DPAD_LAST));
                own = pad ? 4'(4'b0001 << (k - int'(KEY_DPAD_FIRST))) : 4'd0;
                if (pressed[KEY_POS[k]]) begin
                    // another direction owns the d-pad: drop the press
                    if (pad && pad_owner != 0) continue;
                    pad_owner = pad_owner | own;
                    held_keys[k] = 1'b1;
                    add_event(EV_PRESS, k, Q_ONE_MAX);
                end else if (released[KEY_POS[k]]) begin
                    if (pad && (pad_owner & own) == 0) continue;
                    pad_owner = pad_owner & ~own;
                    held_keys[k] = 1'b0;
                    add_event(EV_RELEASE, k, 16'sd0);
                end
            end
            set_axis(0, trigger_q(r.lt, cfg_thr));
            set_axis(1, trigger_q(r.rt, cfg_thr));
            set_axis(2, stick_q(r.lx, cfg_ldz));
            set_axis(3, stick_q(r.ly, cfg_ldz));
            set_axis(4, stick_q(r.rx, cfg_rdz));
            set_axis(5, stick_q(r.ry, cfg_rdz));
            prev_mask = r.mask;
        end
        if (derived_events.size() > 0) derived_events[derived_events.size() - 1].last = 1'b1;
    endfunction

    function automatic gp_req_t mk_poll(input logic [15:0] mask, input int lt, input int rt,
                                        input int lx, input int ly, input int rx, input int ry);
        gp_req_t r;
        r.op   = OP_POLL;
        r.mask = mask;
        r.lt   = 8'(lt);
        r.rt   = 8'(rt);
        r.lx   = 16'(lx);
        r.ly   = 16'(ly);
        r.rx   = 16'(rx);
        r.ry   = 16'(ry);
        return r;
    endfunction

    function automatic gp_req_t mk_lost();
        gp_req_t r;
        r = '0;
        r.op = OP_LOST;
        return r;
    endfunction

    function automatic gp_event_t mk_event(input t_ev_kind kind, input int code, input int value,
                                           input logic last);
        gp_event_t e;
        e.kind  = kind;
        e.code  = 4'(code);
        e.value = 16'(value);
        e.last  = last;
        return e;
    endfunction

    function automatic logic [7:0] pick_trigger();
        int v;
        case ($urandom_range(0, 4))
            0:       v = 0;
            1:       v = 255;
            2:       v = int'(cfg_thr) + int'($urandom_range(0, 4)) - 2;
            default: v = int'($urandom_range(0, 255));
        endcase
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return 8'(v);
    endfunction

    function automatic logic signed [15:0] pick_stick(input logic [14:0] dz);
        int v;
        int off;
        off = int'($urandom_range(0, 4)) - 2;
        case ($urandom_range(0, 5))
            0:       v = 0;
            1:       v = int'(dz) + off;
            2:       v = -int'(dz) + off;
            3:       v = $urandom_range(0, 1) ? 32767 : -32768;
            default: v = int'($urandom_range(0, 65535)) - 32768;
        endcase
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    // Mostly small edits of the held buttons, with some noise masks and lost devices
    function automatic gp_req_t rand_req();
        gp_req_t r;
        int      sel;
        sel    = int'($urandom_range(0, 99));
        r.op   = OP_POLL;
        r.mask = stim_mask;
        if (sel < 5) begin
            r.op   = OP_LOST;
            r.mask = 16'($urandom);
        end else if (sel < 15) begin
            r.mask = 16'($urandom);
        end else begin
            repeat ($urandom_range(1, 2)) begin
                if ($urandom_range(0, 2) == 0) r.mask[$urandom_range(0, 3)] ^= 1'b1;
                else r.mask[$urandom_range(0, 15)] ^= 1'b1;
            end
        end
        r.lt = pick_trigger();
        r.rt = pick_trigger();
        r.lx = pick_stick(cfg_ldz);
        r.ly = pick_stick(cfg_ldz);
        r.rx = pick_stick(cfg_rdz);
        r.ry = pick_stick(cfg_rdz);
        if (r.op == OP_POLL) stim_mask = r.mask;
        return r;
    endfunction

    task automatic send_req(input gp_req_t r, input int n_typed, input gp_event_t e0,
                            input gp_event_t e1);
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.op            <= r.op;
        in_ch.button_mask   <= r.mask;
        in_ch.left_trigger  <= r.lt;
        in_ch.right_trigger <= r.rt;
        in_ch.left_x        <= r.lx;
        in_ch.left_y        <= r.ly;
        in_ch.right_x       <= r.rx;
        in_ch.right_y       <= r.ry;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        derive_events(r);
        if (n_typed == PREDICTED) begin
            foreach (derived_events[i]) owed_events.push_back(derived_events[i]);
        end else begin
            if (n_typed > 0) owed_events.push_back(e0);
            if (n_typed > 1) owed_events.push_back(e1);
        end
    endtask

    task automatic wait_idle();
        while (owed_events.size() != 0) @(posedge i_clk);
        // a request with no events may still be in flight
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_TRIG_THR: cfg_thr = data[7:0];
            REG_LEFT_DZ:  cfg_ldz = data[14:0];
            default:      cfg_rdz = data[14:0];
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_config(input logic [7:0] thr, input logic [14:0] ldz,
                                input logic [14:0] rdz);
        in_ch.valid <= 1'b0;
        wait_idle();
        apb_write(REG_TRIG_THR, {24'd0, thr});
        apb_write(REG_LEFT_DZ, {17'd0, ldz});
        apb_write(REG_RIGHT_DZ, {17'd0, rdz});
    endtask

    task automatic run_random(input int n);
        repeat (n) send_req(rand_req(), PREDICTED, NO_EVENT, NO_EVENT);
    endtask

    // Event sink: check each event, stall in short bursts, one long hold-off
    initial begin
        gp_event_t want;
        int        stall_left;
        int        hold_left;
        bit        hold_done;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        ev_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && ev_ch.valid && ev_ch.ready) begin
                if (owed_events.size() == 0) begin
                    flag_mismatch($sformatf("unexpected event kind %0d code %0d value %0d",
                                            ev_ch.event_kind, ev_ch.event_code,
                                            ev_ch.event_value));
                end else begin
                    want = owed_events.pop_front();
                    if (ev_ch.event_kind !== want.kind)
                        flag_mismatch($sformatf("event %0d kind: got %0d, want %0d",
                                                events_seen, ev_ch.event_kind, want.kind));
                    if (ev_ch.event_code !== want.code)
                        flag_mismatch($sformatf("event %0d code: got %0d, want %0d",
                                                events_seen, ev_ch.event_code, want.code));
                    if (ev_ch.event_value !== want.value)
                        flag_mismatch($sformatf("event %0d value: got %0d, want %0d",
                                                events_seen, ev_ch.event_value, want.value));
                    if (ev_ch.last !== want.last)
                        flag_mismatch($sformatf("event %0d last: got %0b, want %0b",
                                                events_seen, ev_ch.last, want.last));
                end
                events_seen++;
            end
            if (hold_left > 0) begin
                hold_left--;
                ev_ch.ready <= 1'b0;
            end else if (!hold_done && events_seen >= HOLD_AFTER) begin
                // long hold: let the block back up and stall its input
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                ev_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                ev_ch.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = int'($urandom_range(0, 2));
                ev_ch.ready <= 1'b0;
            end else begin
                ev_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        gp_row_t row;
        i_rst_n             <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        in_ch.valid         <= 1'b0;
        in_ch.op            <= OP_POLL;
        in_ch.button_mask   <= '0;
        in_ch.left_trigger  <= '0;
        in_ch.right_trigger <= '0;
        in_ch.left_x        <= '0;
        in_ch.left_y        <= '0;
        in_ch.right_x       <= '0;
        in_ch.right_y       <= '0;

        // at rest after reset, lost device with nothing held, one button press and release
        dir_rows.push_back('{1'b0, 8'd0, 15'd0, 15'd0, mk_poll(16'h0000, 0, 0, 0, 0, 0, 0),
                             0, NO_EVENT, NO_EVENT});
        dir_rows.push_back('{1'b0, 8'd0, 15'd0, 15'd0, mk_lost(), 0, NO_EVENT, NO_EVENT});
        dir_rows.push_back('{1'b0, 8'd0, 15'd0, 15'd0, mk_poll(16'h1000, 0, 0, 0, 0, 0, 0),
                             1, mk_event(EV_PRESS, 0, 32767, 1'b1), NO_EVENT});
        dir_rows.push_back('{1'b0, 8'd0, 15'd0, 15'd0, mk_poll(16'h0000, 0, 0, 0, 0, 0, 0),
                             1, mk_event(EV_RELEASE, 0, 0, 1'b1), NO_EVENT});
        // everything pressed at full scale, then d-left let go, then all released
        dir_rows.push_back('{1'b0, 8'd0, 15'd0, 15'd0,
                             mk_poll(16'hFFFF, 255, 255, 32767, -32768, 32767, -32768),
                             PREDICTED, NO_EVENT, NO_EVENT});
        dir_rows.push_back('{1'b0, 8'd0, 15'd0, 15'd0,
                             mk_poll(16'hFFFB, 255, 255, 32767, -32768, 32767, -32768),
                             PREDICTED, NO_EVENT, NO_EVENT});
        dir_rows.push_back('{1'b0, 8'd0, 15'd0, 15'd0, mk_poll(16'h0000, 0, 0, 0, 0, 0, 0),
                             PREDICTED, NO_EVENT, NO_EVENT});
        // unused mask bits give no events either way
        dir_rows.push_back('{1'b0, 8'd0, 15'd0, 15'd0, mk_poll(16'h0C00, 0, 0, 0, 0, 0, 0),
                             0, NO_EVENT, NO_EVENT});
        dir_rows.push_back('{1'b0, 8'd0, 15'd0, 15'd0, mk_poll(16'h0000, 0, 0, 0, 0, 0, 0),
                             0, NO_EVENT, NO_EVENT});
        // d-pad: right owns, up is blocked, release of up is not owned
        dir_rows.push_back('{1'b0, 8'd0, 15'd0, 15'd0, mk_poll(16'h0008, 0, 0, 0, 0, 0, 0),
                             1, mk_event(EV_PRESS, 7, 32767, 1'b1), NO_EVENT});
        dir_rows.push_back('{1'b0, 8'd0, 15'd0, 15'd0, mk_poll(16'h0009, 0, 0, 0, 0, 0, 0),
                             0, NO_EVENT, NO_EVENT});
        dir_rows.push_back('{1'b0, 8'd0, 15'd0, 15'd0, mk_poll(16'h0001, 0, 0, 0, 0, 0, 0),
                             1, mk_event(EV_RELEASE, 7, 0, 1'b1), NO_EVENT});
        dir_rows.push_back('{1'b0, 8'd0, 15'd0, 15'd0, mk_poll(16'h0000, 0, 0, 0, 0, 0, 0),
                             0, NO_EVENT, NO_EVENT});
        // dead band edges
        dir_rows.push_back('{1'b0, 8'd0, 15'd0, 15'd0, mk_poll(16'h0000, 30, 31, 0, 0, 0, 0),
                             PREDICTED, NO_EVENT, NO_EVENT});
        dir_rows.push_back('{1'b0, 8'd0, 15'd0, 15'd0,
                             mk_poll(16'h0000, 0, 0, 7849, -7849, 8689, -8689),
                             PREDICTED, NO_EVENT, NO_EVENT});
        // saturation at both ends
        dir_rows.push_back('{1'b0, 8'd0, 15'd0, 15'd0, mk_poll(16'h0000, 255, 0, 0, 0, 0, 0),
                             1, mk_event(EV_AXIS, 0, 32767, 1'b1), NO_EVENT});
        dir_rows.push_back('{1'b0, 8'd0, 15'd0, 15'd0,
                             mk_poll(16'h0000, 0, 0, -32768, 0, 0, 0), 2,
                             mk_event(EV_AXIS, 0, 0, 1'b0), mk_event(EV_AXIS, 2, -32768, 1'b1)});
        dir_rows.push_back('{1'b0, 8'd0, 15'd0, 15'd0,
                             mk_poll(16'h0000, 0, 0, 7850, -7850, 8690, -8690),
                             PREDICTED, NO_EVENT, NO_EVENT});
        // lost device with keys and axes held, then again with nothing held
        dir_rows.push_back('{1'b0, 8'd0, 15'd0, 15'd0,
                             mk_poll(16'h3005, 100, 200, 12345, -23456, 30000, -9000),
                             PREDICTED, NO_EVENT, NO_EVENT});
        dir_rows.push_back('{1'b0, 8'd0, 15'd0, 15'd0, mk_lost(), PREDICTED, NO_EVENT, NO_EVENT});
        dir_rows.push_back('{1'b0, 8'd0, 15'd0, 15'd0, mk_lost(), 0, NO_EVENT, NO_EVENT});
        // full threshold and full deadzones: every axis reads zero
        dir_rows.push_back('{1'b1, 8'd255, 15'd32767, 15'd32767,
                             mk_poll(16'h0000, 255, 255, 32767, -32768, 32767, -32768),
                             0, NO_EVENT, NO_EVENT});
        dir_rows.push_back('{1'b1, 8'd0, 15'd0, 15'd0,
                             mk_poll(16'h5AA5, 1, 255, 1, -1, 32767, -32768),
                             PREDICTED, NO_EVENT, NO_EVENT});
        dir_rows.push_back('{1'b0, 8'd0, 15'd0, 15'd0, mk_poll(16'hA55A, 0, 0, 0, 0, 0, 0),
                             PREDICTED, NO_EVENT, NO_EVENT});
        dir_rows.push_back('{1'b0, 8'd0, 15'd0, 15'd0, mk_lost(), PREDICTED, NO_EVENT, NO_EVENT});

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.wr_cfg) apply_config(row.thr, row.ldz, row.rdz);
            send_req(row.req, row.n_typed, row.ev0, row.ev1);
        end

        apply_config(TRIG_THR_RESET, LDZ_RESET, RDZ_RESET);
        run_random(60);
        apply_config(8'($urandom_range(0, 254)), 15'($urandom_range(0, 32766)),
                     15'($urandom_range(0, 32766)));
        run_random(50);
        apply_config(8'd254, 15'd32766, 15'd32766);
        run_random(30);
        apply_config(8'd0, 15'd0, 15'd0);
        run_random(40);
        apply_config(8'($urandom_range(0, 254)), 15'($urandom_range(0, 32766)),
                     15'($urandom_range(0, 32766)));
        calm = 1'b1;
        run_random(70);
        in_ch.valid <= 1'b0;

        wait_idle();
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
